>>> rtl/assert_macros.svh
// Assertion macros shared by the divisor enumerator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DVE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DVE_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DVE_ASSERT(lbl, clk, rst_n, prop, msg)
`define DVE_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/dve_pkg.sv
// Types and constants of the divisor enumerator.
`default_nettype none
package dve_pkg;

  localparam int CNT_W        = 6;
  localparam int MAX_RESULTS  = 48;
  localparam int COUNT_MAX    = 63;
  localparam int RESET_TARGET = 18;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam logic REG_TARGET = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WAIT,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

endpackage
`default_nettype wire

>>> rtl/divisor_enumerator_top.sv
// Top level of the divisor enumerator: config register and unit wiring.
//
//  channel  direction  handshake             payload
//  in       request    in_valid/in_ready     in_value
//  out      result     out_valid/out_ready   out_divisor, out_count, out_last, out_match
//  cfg      APB write  cfg_psel/cfg_penable  target_count at byte address 0
//
// Every candidate from 1 to the value goes through the shared remainder unit,
// and each divisor sent out passes through the emit state; a zero value skips
// the division and sends one result.
// in_ready is high only between requests; a stalled output holds the next
// divisor in the sequencer. Synchronous reset, no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module divisor_enumerator_top
  import dve_pkg::*;
#(
  parameter int VALUE_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [VALUE_BITS-1:0]      out_divisor,
  output logic [CNT_W-1:0]           out_count,
  output logic                       out_last,
  output logic                       out_match,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_AW-1:0]     cfg_paddr,
  input  wire logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]          cfg_prdata,
  output logic                       cfg_pready
);

  logic [CNT_W-1:0]      target_r, target_nxt;
  logic                  cfg_wr;
  logic                  rem_start;
  logic [VALUE_BITS-1:0] rem_dividend;
  logic [VALUE_BITS-1:0] rem_divisor;
  rem_stat_t             rem_stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    target_nxt = target_r;
    if (cfg_wr && (cfg_paddr[CFG_AW-1] == REG_TARGET)) begin
      target_nxt = cfg_pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= CNT_W'(RESET_TARGET);
    end else begin
      target_r <= target_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_TARGET) ?
                      {{(CFG_DW - CNT_W){1'b0}}, target_r} : '0;

  dve_rem_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .stat     (rem_stat)
  );

  dve_seq #(
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .target       (target_r),
    .rem_start    (rem_start),
    .rem_dividend (rem_dividend),
    .rem_divisor  (rem_divisor),
    .rem_stat     (rem_stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_divisor  (out_divisor),
    .out_count    (out_count),
    .out_last     (out_last),
    .out_match    (out_match)
  );

  `DVE_ASSERT(a_busy_after_req, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready after request")
  `DVE_NEVER(a_match_only_last, clk, rst_n, out_valid && !out_last && out_match, "match not on last")
  `DVE_NEVER(a_nonzero_count, clk, rst_n, out_valid && (out_divisor != '0) && (out_count == '0), "zero count")
  `DVE_ASSERT(a_cfg_write, clk, rst_n, cfg_wr && (cfg_paddr[CFG_AW-1] == REG_TARGET) |=> target_r == $past(cfg_pwdata[CNT_W-1:0]), "target not written")

endmodule
`default_nettype wire

>>> rtl/dve_rem_unit.sv
// Shared restoring remainder unit, one quotient bit per cycle.
`default_nettype none
module dve_rem_unit
  import dve_pkg::*;
#(
  parameter int VALUE_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [VALUE_BITS-1:0] divisor,
  output rem_stat_t                  stat
);

  localparam int STEP_W = $clog2(VALUE_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [VALUE_BITS:0]   rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] sh_r, sh_nxt;
  logic [VALUE_BITS-1:0] div_r, div_nxt;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   div_ext;

  assign trial   = {rem_r[VALUE_BITS-1:0], sh_r[VALUE_BITS-1]};
  assign div_ext = {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(VALUE_BITS);
      rem_nxt  = '0;
      sh_nxt   = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (step_r != '0) begin
        rem_nxt  = (trial >= div_ext) ? (trial - div_ext) : trial;
        sh_nxt   = {sh_r[VALUE_BITS-2:0], 1'b0};
        step_nxt = step_r - STEP_W'(1);
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    div_r <= div_nxt;
  end

  assign stat.done = busy_r && (step_r == '0);
  assign stat.zero = (rem_r == '0);

endmodule
`default_nettype wire

>>> rtl/dve_seq.sv
// Candidate sequencer and result register of the divisor enumerator.
`default_nettype none
module dve_seq
  import dve_pkg::*;
#(
  parameter int VALUE_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic [CNT_W-1:0]      target,
  output logic                       rem_start,
  output logic [VALUE_BITS-1:0]      rem_dividend,
  output logic [VALUE_BITS-1:0]      rem_divisor,
  input  wire rem_stat_t             rem_stat,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [VALUE_BITS-1:0]      out_divisor,
  output logic [CNT_W-1:0]           out_count,
  output logic                       out_last,
  output logic                       out_match
);

  seq_state_t            state_r, state_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [VALUE_BITS-1:0] cand_r, cand_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      emit_n_r, emit_n_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_div_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic                  out_last_r;
  logic                  out_match_r;
  logic                  slot_free;
  logic                  is_final;
  logic                  keep;
  logic                  load;

  assign slot_free = !out_valid_r || out_ready;
  assign is_final  = (cand_r == val_r);
  assign keep      = rem_stat.zero &&
                     (is_final || (emit_n_r < CNT_W'(MAX_RESULTS - 1)));
  assign load      = (state_r == ST_EMIT) && slot_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_value == '0) ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (rem_stat.done) begin
          state_nxt = keep ? ST_EMIT : ST_DIV;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = is_final ? ST_IDLE : ST_DIV;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs to neighbors
  always_comb begin
    in_ready  = 1'b0;
    rem_start = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_DIV:  rem_start = 1'b1;
      default: begin
        in_ready  = 1'b0;
        rem_start = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    val_nxt    = val_r;
    cand_nxt   = cand_r;
    cnt_nxt    = cnt_r;
    emit_n_nxt = emit_n_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt    = in_value;
          cnt_nxt    = '0;
          emit_n_nxt = '0;
          cand_nxt   = (in_value == '0) ? '0 : VALUE_BITS'(1);
        end
      end
      ST_WAIT: begin
        if (rem_stat.done) begin
          if (rem_stat.zero && (cnt_r != CNT_W'(COUNT_MAX))) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (!keep) begin
            cand_nxt = cand_r + VALUE_BITS'(1);
          end
        end
      end
      ST_EMIT: begin
        if (slot_free && !is_final) begin
          emit_n_nxt = emit_n_r + CNT_W'(1);
          cand_nxt   = cand_r + VALUE_BITS'(1);
        end
      end
      default: begin
        cand_nxt = cand_r;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      val_r       <= '0;
      cand_r      <= '0;
      cnt_r       <= '0;
      emit_n_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      val_r       <= val_nxt;
      cand_r      <= cand_nxt;
      cnt_r       <= cnt_nxt;
      emit_n_r    <= emit_n_nxt;
    end
    if (load) begin
      out_div_r   <= cand_r;
      out_cnt_r   <= cnt_r;
      out_last_r  <= is_final;
      out_match_r <= is_final && (cnt_r == target);
    end
  end

  assign rem_dividend = val_r;
  assign rem_divisor  = cand_r;
  assign out_valid    = out_valid_r;
  assign out_divisor  = out_div_r;
  assign out_count    = out_cnt_r;
  assign out_last     = out_last_r;
  assign out_match    = out_match_r;

endmodule
`default_nettype wire

>>> tb/divisor_enumerator_top_tb.sv
// Self-checking testbench for the divisor enumerator: directed table plus random phases.
module divisor_enumerator_top_tb;
  import dve_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB = 12;
  localparam int unsigned VALUE_MAX = (1 << VB) - 1;
  localparam logic [CFG_AW-1:0] TARGET_ADDR = CFG_AW'(4 * REG_TARGET);
  localparam logic [CFG_AW-1:0] UNMAPPED_ADDR = TARGET_ADDR + CFG_AW'(4);
  localparam int QUIET_LIMIT = 250000;
  localparam int HOLD_CYCLES = 400;
  localparam int END_SLACK = 64;
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [VB-1:0]    divisor;
    logic [CNT_W-1:0] count;
    logic             last;
    logic             match;
  } div_result_t;

  typedef struct packed {
    logic [VB-1:0] value;
    logic          typed;
    div_result_t   res;
  } dir_row_t;

  // typed rows carry their single result; the rest go through the predictor
  localparam dir_row_t DIRECTED [0:19] = '{
    '{12'd0,    1'b1, '{12'd0, 6'd0, 1'b1, 1'b0}},
    '{12'd1,    1'b1, '{12'd1, 6'd1, 1'b1, 1'b0}},
    '{12'd2,    1'b0, '0},
    '{12'd3,    1'b0, '0},
    '{12'd4,    1'b0, '0},
    '{12'd7,    1'b0, '0},
    '{12'd12,   1'b0, '0},
    '{12'd36,   1'b0, '0},
    '{12'd64,   1'b0, '0},
    '{12'd97,   1'b0, '0},
    '{12'd180,  1'b0, '0},
    '{12'd255,  1'b0, '0},
    '{12'd256,  1'b0, '0},
    '{12'd1000, 1'b0, '0},
    '{12'd1024, 1'b0, '0},
    '{12'd2048, 1'b0, '0},
    '{12'd2520, 1'b0, '0},
    '{12'd4093, 1'b0, '0},
    '{12'd4095, 1'b0, '0},
    '{12'd0,    1'b1, '{12'd0, 6'd0, 1'b1, 1'b0}}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [VB-1:0]     in_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [VB-1:0]     out_divisor;
  logic [CNT_W-1:0]  out_count;
  logic              out_last;
  logic              out_match;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // typed expectation travelling with the request on the input channel
  logic              req_typed = 1'b0;
  div_result_t       req_typed_res = '0;

  div_result_t       pending_divisors[$];
  logic [CNT_W-1:0]  target_shadow = CNT_W'(RESET_TARGET);
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  logic              rx_hold = 1'b0;
  int                errors = 0;
  int                requests_seen = 0;
  int                results_seen = 0;
  int                matches_seen = 0;
  int                deepest_count = 0;
  int                quiet_cycles = 0;

  divisor_enumerator_top #(.VALUE_BITS(VB)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_divisor (out_divisor),
    .out_count   (out_count),
    .out_last    (out_last),
    .out_match   (out_match),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  function automatic void queue_result(input div_result_t r);
    pending_divisors = {pending_divisors, r};
  endfunction

  // trial division over every candidate, saturating count, capped listing
  function automatic void expand_divisors(input logic [VB-1:0] v);
    int unsigned tally;
    int unsigned listed;
    div_result_t r;
    tally = 0;
    listed = 0;
    if (v == 0) begin
      r.divisor = '0;
      r.count = '0;
      r.last = 1'b1;
      r.match = (target_shadow == 0);
      queue_result(r);
      return;
    end
    for (int unsigned c = 1; c <= v; c++) begin
      if (v % c != 0) continue;
      if (tally < COUNT_MAX) tally++;
      r.divisor = VB'(c);
      r.count = CNT_W'(tally);
      if (c == v) begin
        r.last = 1'b1;
        r.match = (CNT_W'(tally) == target_shadow);
        queue_result(r);
      end else if (listed < MAX_RESULTS - 1) begin
        r.last = 1'b0;
        r.match = 1'b0;
        queue_result(r);
        listed++;
      end
    end
  endfunction

  always @(posedge clk) begin
    div_result_t got;
    div_result_t want;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          (cfg_paddr >> 2) == REG_TARGET)
        target_shadow = cfg_pwdata[CNT_W-1:0];
      if (out_valid && out_ready) begin
        got = '{out_divisor, out_count, out_last, out_match};
        results_seen++;
        if (got.last && got.match) matches_seen++;
        if (int'(got.count) > deepest_count) deepest_count = got.count;
        if (pending_divisors.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: unexpected result divisor=%0d count=%0d last=%0d match=%0d",
                     $time, got.divisor, got.count, got.last, got.match);
        end else begin
          want = pending_divisors.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_CAP)
              $display("%0t: divisor/count/last/match expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       $time, want.divisor, want.count, want.last, want.match,
                       got.divisor, got.count, got.last, got.match);
          end
        end
      end
      if (in_valid && in_ready) begin
        requests_seen++;
        if (req_typed) queue_result(req_typed_res);
        else expand_divisors(in_value);
      end
    end
  end

  always @(negedge clk)
    out_ready <= rst_n && !rx_hold && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // called at a falling edge; leaves valid high after acceptance
  task automatic send_value(input logic [VB-1:0] v, input logic typed,
                            input div_result_t res);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    req_typed <= typed;
    req_typed_res <= res;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [VB-1:0] pick_value(input int unsigned ceiling);
    int unsigned roll;
    roll = $urandom_range(99);
    if (ceiling < 64) return VB'($urandom_range(ceiling));
    if (roll < 6) return VB'($urandom_range(VALUE_MAX));
    if (roll < 40) return VB'($urandom_range(63));
    return VB'($urandom_range(400, 64));
  endfunction

  task automatic send_random(input int n, input int unsigned ceiling);
    repeat (n) send_value(pick_value(ceiling), 1'b0, '0);
  endtask

  task automatic drain_phase();
    in_valid <= 1'b0;
    while (pending_divisors.size() != 0) @(negedge clk);
  endtask

  task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [CNT_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= CFG_DW'(data);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic hold_output(input int cycles);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) send_value(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].res);
    drain_phase();

    apb_write(UNMAPPED_ADDR, 6'd5);
    apb_write(TARGET_ADDR, 6'd0);
    send_value('0, 1'b0, '0);
    send_random(19, VALUE_MAX);
    drain_phase();

    apb_write(TARGET_ADDR, 6'd48);
    send_idle_pct = 61;
    send_value(12'd2520, 1'b0, '0);
    send_random(19, VALUE_MAX);
    drain_phase();

    apb_write(TARGET_ADDR, 6'd2);
    send_idle_pct = 0;
    recv_stall_pct = 61;
    send_random(20, VALUE_MAX);
    drain_phase();

    apb_write(TARGET_ADDR, 6'd63);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    send_random(20, VALUE_MAX);
    drain_phase();

    apb_write(TARGET_ADDR, CNT_W'($urandom_range(48)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      hold_output(HOLD_CYCLES);
      send_random(20, 40);
    join
    drain_phase();

    repeat (END_SLACK) @(posedge clk);
    $display("Covered %0d requests and %0d divisor results, %0d with match set, top count %0d.",
             requests_seen, results_seen, matches_seen, deepest_count);
    $display("Targets 18, 0, 48, 2, 63 and a random one, an unmapped write, mixed stalls.");
    if (errors == 0 && pending_divisors.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dve_pkg.sv
rtl/dve_rem_unit.sv
rtl/dve_seq.sv
rtl/divisor_enumerator_top.sv
tb/divisor_enumerator_top_tb.sv
